// ===== hdl/bgr_pkg.sv =====
`default_nettype none
package bgr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int DST_MAX_DEF    = 1024;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int SRC_W      = 8;
  localparam int DST_W      = 10;
  localparam int SIZE_REG_W = 9;
  localparam int STEP_W     = 24;
  localparam int POS_FRAC   = 16;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Depth of the result queue
  localparam int OUT_DEPTH  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_X_STEP     = 2'd2,
    REG_Y_STEP     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_t;

  // One store access per cycle: a pixel write or a 2x2 neighbourhood read
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [COORD_W-1:0] wcol;
    logic [COORD_W-1:0] wrow;
    logic [PIX_W-1:0]   wpix;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
  } store_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/bgr_ram.sv =====
`default_nettype none
module bgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/bgr_axis.sv =====
`default_nettype none
module bgr_axis #(
  parameter int MAX_SIZE  = 256,
  parameter int FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic [bgr_pkg::DST_W-1:0]       index,
  input  logic [bgr_pkg::STEP_W-1:0]      step,
  input  logic [bgr_pkg::SIZE_REG_W-1:0]  size,
  output logic [$clog2(MAX_SIZE)-1:0]     tap,
  output logic [FRAC_BITS-1:0]            frac
);
  import bgr_pkg::*;

  localparam int TW         = $clog2(MAX_SIZE);
  localparam int SW         = $clog2(MAX_SIZE + 1);
  localparam int PW         = DST_W + STEP_W;
  localparam int CLAMP_FRAC = (99 * (1 << FRAC_BITS)) / 100;

  logic [PW-1:0] pos;
  logic [SW-1:0] sz;
  logic [PW-1:0] thr;

  // Position in Q16
  always_ff @(posedge clk) begin
    pos <= PW'(index) * PW'(step);
  end

  // Saturate the configured size into range
  always_comb begin
    if (size < SIZE_REG_W'(2)) begin
      sz = SW'(2);
    end else if (size > MAX_SIZE) begin
      sz = SW'(MAX_SIZE);
    end else begin
      sz = SW'(size);
    end
    thr = PW'(sz - SW'(1)) << POS_FRAC;
  end

  // Split into tap and fraction, clamping at the last pair of taps
  always_ff @(posedge clk) begin
    if (pos >= thr) begin
      tap  <= TW'(sz - SW'(2));
      frac <= FRAC_BITS'(CLAMP_FRAC);
    end else begin
      tap  <= pos[POS_FRAC +: TW];
      frac <= pos[POS_FRAC-1 -: FRAC_BITS];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bgr_store.sv =====
`default_nettype none
module bgr_store #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk,
  input  bgr_pkg::store_cmd_t       cmd,
  output logic [bgr_pkg::PIX_W-1:0] pa,
  output logic [bgr_pkg::PIX_W-1:0] pb,
  output logic [bgr_pkg::PIX_W-1:0] pc,
  output logic [bgr_pkg::PIX_W-1:0] pd
);
  import bgr_pkg::*;

  // Four banks by row and column parity: any 2x2 neighbourhood hits each once
  localparam int CWX = $clog2(MAX_WIDTH);
  localparam int CWY = $clog2(MAX_HEIGHT);
  localparam int BC  = (MAX_WIDTH + 1) / 2;
  localparam int BR  = (MAX_HEIGHT + 1) / 2;
  localparam int BD  = BC * BR;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;

  function automatic logic [AW-1:0] bank_addr(input logic [CWY-1:0] r,
                                               input logic [CWX-1:0] c);
    bank_addr = AW'(r >> 1) * AW'(BC) + AW'(c >> 1);
  endfunction

  logic [CWX-1:0]   x0;
  logic [CWY-1:0]   y0;
  logic [CWX-1:0]   wcol;
  logic [CWY-1:0]   wrow;
  logic [PIX_W-1:0] q [4];
  logic             px;
  logic             py;

  assign x0   = cmd.x0[CWX-1:0];
  assign y0   = cmd.y0[CWY-1:0];
  assign wcol = cmd.wcol[CWX-1:0];
  assign wrow = cmd.wrow[CWY-1:0];

  for (genvar bk = 0; bk < 4; bk++) begin : g_bank
    localparam int RP = bk / 2;
    localparam int CP = bk % 2;
    logic [CWY-1:0] rrow;
    logic [CWX-1:0] rcol;
    logic           we;

    // Pick the row and column of this parity within the neighbourhood
    assign rrow = (y0[0] == 1'(RP)) ? y0 : y0 + 1'b1;
    assign rcol = (x0[0] == 1'(CP)) ? x0 : x0 + 1'b1;
    assign we   = cmd.wr && (wrow[0] == 1'(RP)) && (wcol[0] == 1'(CP));

    bgr_ram #(.WIDTH(PIX_W), .DEPTH(BD)) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (bank_addr(wrow, wcol)),
      .wdata (cmd.wpix),
      .raddr (bank_addr(rrow, rcol)),
      .rdata (q[bk])
    );
  end

  // Hold the tap parities alongside the read data
  always_ff @(posedge clk) begin
    px <= x0[0];
    py <= y0[0];
  end

  // Route banks back to near/far taps
  always_comb begin
    pa = py  ? (px  ? q[3] : q[2]) : (px  ? q[1] : q[0]);
    pb = py  ? (!px ? q[3] : q[2]) : (!px ? q[1] : q[0]);
    pc = !py ? (px  ? q[3] : q[2]) : (px  ? q[1] : q[0]);
    pd = !py ? (!px ? q[3] : q[2]) : (!px ? q[1] : q[0]);
  end

endmodule
`default_nettype wire

// ===== hdl/bgr_fifo.sv =====
`default_nettype none
module bgr_fifo #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             rd_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_valid = (count != '0);
  assign rdata    = mem[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count failed to advance");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    !push && pop |=> count == $past(count) - 1'b1)
    else $error("queue count failed to drop");

endmodule
`default_nettype wire

// ===== hdl/bilinear_gray_resampler.sv =====
`default_nettype none
// Requests pass position multiply, tap split, store read and horizontal blend registers.
// Throughput: one word per cycle, set by the single read of each of the four parity
// banks of the pixel store; a write takes effect for every request accepted after it.
// A word is admitted only while the 8-entry result queue has a free credit.
// Reset (synchronous, active high) clears the pipeline and result queue and restores
// the registers; pixel store contents stay undefined until written, with no clearing pass.
module bilinear_gray_resampler #(
  parameter int MAX_WIDTH  = bgr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bgr_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bgr_pkg::FRAC_BITS_DEF,
  parameter int DST_MAX    = bgr_pkg::DST_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [bgr_pkg::SRC_W-1:0]      src_col,
  input  logic [bgr_pkg::SRC_W-1:0]      src_row,
  input  logic [bgr_pkg::PIX_W-1:0]      pixel_in,
  input  logic [bgr_pkg::DST_W-1:0]      dst_col,
  input  logic [bgr_pkg::DST_W-1:0]      dst_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bgr_pkg::PIX_W-1:0]      pixel_out,
  output logic [bgr_pkg::DST_W-1:0]      out_col,
  output logic [bgr_pkg::DST_W-1:0]      out_row
);
  import bgr_pkg::*;

  localparam int CWX   = $clog2(MAX_WIDTH);
  localparam int CWY   = $clog2(MAX_HEIGHT);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int RES_W = PIX_W + 2 * DST_W;
  localparam int ACC_W = FRAC_BITS + 11;
  localparam int HALF  = 1 << (FRAC_BITS - 1);

  // a*(1-f) + b*f rounded, with one multiply
  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0]     a,
                                             input logic [PIX_W-1:0]     b,
                                             input logic [FRAC_BITS-1:0] f);
    logic signed [8:0]       d;
    logic signed [ACC_W-1:0] acc;
    d     = $signed({1'b0, b}) - $signed({1'b0, a});
    acc   = $signed({3'b000, a, {FRAC_BITS{1'b0}}}) + $signed({1'b0, f}) * d
            + $signed(ACC_W'(HALF));
    blend = acc[FRAC_BITS +: PIX_W];
  endfunction

  logic [SIZE_REG_W-1:0] src_width;
  logic [SIZE_REG_W-1:0] src_height;
  logic [STEP_W-1:0]     x_step_q16;
  logic [STEP_W-1:0]     y_step_q16;

  logic                  accept;
  logic                  req_acc;
  logic                  wr_acc;
  logic                  out_acc;
  logic [CNT_W-1:0]      credit;

  logic                  r1, w1, r2, w2, r3, r4;
  logic [DST_W-1:0]      col1, row1, col2, row2, col3, row3, col4, row4;
  logic [COORD_W-1:0]    wcol1, wrow1, wcol2, wrow2;
  logic [PIX_W-1:0]      wpix1, wpix2;
  logic [CWX-1:0]        tap_x;
  logic [CWY-1:0]        tap_y;
  logic [FRAC_BITS-1:0]  frac_x, frac_y, fx3, fy3, fy4;
  logic [PIX_W-1:0]      pa, pb, pc, pd, top4, bot4;
  store_cmd_t            cmd;
  logic [RES_W-1:0]      res_word;
  logic [RES_W-1:0]      out_word;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 9'd256;
      src_height <= 9'd256;
      x_step_q16 <= 24'd65536;
      y_step_q16 <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_REG_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_REG_W-1:0];
        REG_X_STEP:     x_step_q16 <= cfg_data[STEP_W-1:0];
        REG_Y_STEP:     y_step_q16 <= cfg_data[STEP_W-1:0];
        default:        src_width  <= src_width;
      endcase
    end
  end

  // Admit words while the result queue has a credit; drop out-of-range items here
  assign in_ready = (credit < CNT_W'(OUT_DEPTH));
  assign accept   = in_valid && in_ready;
  assign req_acc  = accept && (opcode == OP_REQUEST) && (dst_col < DST_MAX)
                    && (dst_row < DST_MAX);
  assign wr_acc   = accept && (opcode == OP_WRITE) && (src_col < MAX_WIDTH)
                    && (src_row < MAX_HEIGHT);
  assign out_acc  = out_valid && out_ready;

  // Credit count: requests in flight plus results queued
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({req_acc, out_acc})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
    end
  end

  // Position split per axis, two stages
  bgr_axis #(.MAX_SIZE(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk   (clk),
    .index (dst_col),
    .step  (x_step_q16),
    .size  (src_width),
    .tap   (tap_x),
    .frac  (frac_x)
  );

  bgr_axis #(.MAX_SIZE(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk   (clk),
    .index (dst_row),
    .step  (y_step_q16),
    .size  (src_height),
    .tap   (tap_y),
    .frac  (frac_y)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      r1 <= 1'b0;
      w1 <= 1'b0;
      r2 <= 1'b0;
      w2 <= 1'b0;
      r3 <= 1'b0;
      r4 <= 1'b0;
    end else begin
      r1 <= req_acc;
      w1 <= wr_acc;
      r2 <= r1;
      w2 <= w1;
      r3 <= r2;
      r4 <= r3;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    col1  <= dst_col;
    row1  <= dst_row;
    wcol1 <= COORD_W'(src_col);
    wrow1 <= COORD_W'(src_row);
    wpix1 <= pixel_in;
    col2  <= col1;
    row2  <= row1;
    wcol2 <= wcol1;
    wrow2 <= wrow1;
    wpix2 <= wpix1;
    col3  <= col2;
    row3  <= row2;
    fx3   <= frac_x;
    fy3   <= frac_y;
    col4  <= col3;
    row4  <= row3;
    fy4   <= fy3;
    top4  <= blend(pa, pb, fx3);
    bot4  <= blend(pc, pd, fx3);
  end

  // Writes and reads reach the store at the same stage, so order is kept
  always_comb begin
    cmd.wr   = w2;
    cmd.rd   = r2;
    cmd.wcol = wcol2;
    cmd.wrow = wrow2;
    cmd.wpix = wpix2;
    cmd.x0   = COORD_W'(tap_x);
    cmd.y0   = COORD_W'(tap_y);
  end

  bgr_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_store (
    .clk (clk),
    .cmd (cmd),
    .pa  (pa),
    .pb  (pb),
    .pc  (pc),
    .pd  (pd)
  );

  // Vertical blend into the result queue
  assign res_word = {blend(top4, bot4, fy4), col4, row4};

  bgr_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (r4),
    .wdata    (res_word),
    .rd_valid (out_valid),
    .pop      (out_acc),
    .rdata    (out_word)
  );

  assign pixel_out = out_word[RES_W-1 -: PIX_W];
  assign out_col   = out_word[2*DST_W-1 -: DST_W];
  assign out_row   = out_word[DST_W-1:0];

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CNT_W'(OUT_DEPTH))
    else $error("credit count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credit != '0)
    else $error("result shown without a credit");

  a_inflight_credit: assert property (@(posedge clk) disable iff (rst)
    (r1 || r2 || r3 || r4) |-> credit != '0)
    else $error("request in flight without a credit");

  a_store_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.rd))
    else $error("store write and read in the same cycle");

endmodule
`default_nettype wire
